// File: rtl/core/bsfn_pkg.sv
// Shared constants and codes for the bitmap set with find-next search.
package bsfn_pkg;

	localparam int CAPACITY_DEF  = 1024;
	localparam int WORD_BITS_DEF = 64;

	localparam int POS_W   = 10;
	localparam int LEN_W   = 11;
	localparam int COUNT_W = 11;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;

	localparam logic [LEN_W-1:0] ACTIVE_LENGTH_RESET = 11'd1024;

	localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
	localparam logic [OP_W-1:0] OP_TEST   = 2'd1;
	localparam logic [OP_W-1:0] OP_NEXT   = 2'd2;
	localparam logic [OP_W-1:0] OP_NONE   = 2'd3;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
	localparam logic [STAT_W-1:0] STAT_NONE  = 2'd2;

endpackage

// File: rtl/core/bsfn_word_ram.sv
// Single-port-write, single-port-read word memory with registered read data.
module bsfn_word_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 64,
	parameter int AW    = 4
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// File: rtl/core/bitmap_set_find_next_top.sv
// Top level of the bitmap set: insert, membership test and find-next over a word memory.
//
// After reset the block clears its word memory, one word a cycle, all CAPACITY/WORD_BITS
// words (16 at the defaults), and holds in_stall high meanwhile; configuration writes are
// taken at any time. Items are then handled one at a time. Insert and test issue the
// registered read of the word on acceptance, then load the result register in the execute
// state, insert also writing the bit back if it was clear; an out-of-range position and the
// unused op code skip the read. Find next reads one word per cycle through the single read
// port of the word memory, scanning at most CAPACITY/WORD_BITS words. A waiting result holds
// the block at its final step until taken. WORD_BITS must be a power of two.
module bitmap_set_find_next_top #(
	parameter int WORD_BITS = bsfn_pkg::WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [bsfn_pkg::OP_W-1:0]     op,
	input  logic [bsfn_pkg::POS_W-1:0]    position,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          present,
	output logic [bsfn_pkg::POS_W-1:0]    found_position,
	output logic [bsfn_pkg::COUNT_W-1:0]  member_count,
	output logic [bsfn_pkg::STAT_W-1:0]   status,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bsfn_pkg::LEN_W-1:0]    cfg_data
);

	localparam int CAPACITY  = bsfn_pkg::CAPACITY_DEF;
	localparam int NUM_WORDS = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
	localparam int WIDX_W    = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
	localparam int BIT_W     = $clog2(WORD_BITS);

	localparam logic [1:0] ST_CLR  = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0]                      state_q;
	logic [WIDX_W-1:0]               clr_idx_q;
	logic [bsfn_pkg::LEN_W-1:0]      active_length_q;
	logic [bsfn_pkg::COUNT_W-1:0]    count_q;

	logic [bsfn_pkg::OP_W-1:0]       op_q;
	logic [bsfn_pkg::POS_W-1:0]      pos_q;
	logic [bsfn_pkg::LEN_W-1:0]      lim_q;
	logic                            bad_q;
	logic                            first_q;
	logic [WIDX_W-1:0]               word_q;

	logic                            out_valid_q;
	logic                            present_q;
	logic [bsfn_pkg::POS_W-1:0]      found_q;
	logic [bsfn_pkg::COUNT_W-1:0]    count_out_q;
	logic [bsfn_pkg::STAT_W-1:0]     status_q;

	logic [bsfn_pkg::LEN_W-1:0]      lim;
	logic                            accept;
	logic                            in_bad;
	logic                            out_free;

	logic                            wr_en;
	logic [WIDX_W-1:0]               wr_addr;
	logic [WORD_BITS-1:0]            wr_data;
	logic                            rd_en;
	logic [WIDX_W-1:0]               rd_addr;
	logic [WORD_BITS-1:0]            rd_data;

	logic [BIT_W-1:0]                bit_sel;
	logic [WORD_BITS-1:0]            masked;
	logic                            ff_hit;
	logic [BIT_W-1:0]                ff_idx;
	logic [31:0]                     hit_pos;
	logic [31:0]                     nxt_word;
	logic                            terminal;
	logic                            cont;
	logic                            done;
	logic                            do_write;
	logic                            r_present;
	logic [bsfn_pkg::POS_W-1:0]      r_found;
	logic [bsfn_pkg::STAT_W-1:0]     r_status;

	bsfn_word_ram #(
		.DEPTH (NUM_WORDS),
		.WIDTH (WORD_BITS),
		.AW    (WIDX_W)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign lim       = (32'(active_length_q) > CAPACITY) ? bsfn_pkg::LEN_W'(CAPACITY)
	                                                     : active_length_q;
	assign in_stall  = (state_q != ST_IDLE);
	assign accept    = in_valid && !in_stall;
	assign in_bad    = (op == bsfn_pkg::OP_NONE) || ({1'b0, position} >= lim);
	assign out_free  = !out_valid_q || !out_stall;
	assign cfg_ready = 1'b1;

	assign bit_sel = pos_q[BIT_W-1:0];
	assign masked  = first_q ? (rd_data & ({WORD_BITS{1'b1}} << bit_sel)) : rd_data;

	always_comb begin
		ff_hit = 1'b0;
		ff_idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (masked[i]) begin
				ff_hit = 1'b1;
				ff_idx = BIT_W'(i);
			end
		end
	end

	assign hit_pos  = (32'(word_q) << BIT_W) + 32'(ff_idx);
	assign nxt_word = 32'(word_q) + 32'd1;

	always_comb begin
		terminal  = 1'b1;
		do_write  = 1'b0;
		r_present = 1'b0;
		r_found   = '0;
		r_status  = bsfn_pkg::STAT_OK;
		if (bad_q) begin
			if (op_q != bsfn_pkg::OP_NONE) begin
				r_status = bsfn_pkg::STAT_RANGE;
			end
		end else begin
			case (op_q)
				bsfn_pkg::OP_INSERT: begin
					do_write = !rd_data[bit_sel];
				end
				bsfn_pkg::OP_TEST: begin
					r_present = rd_data[bit_sel];
				end
				bsfn_pkg::OP_NEXT: begin
					if (ff_hit) begin
						if (hit_pos >= 32'(lim_q)) begin
							r_status = bsfn_pkg::STAT_NONE;
						end else begin
							r_found = bsfn_pkg::POS_W'(hit_pos);
						end
					end else if (nxt_word >= NUM_WORDS || nxt_word * WORD_BITS >= 32'(lim_q)) begin
						r_status = bsfn_pkg::STAT_NONE;
					end else begin
						terminal = 1'b0;
					end
				end
				default: begin
					terminal = 1'b1;
				end
			endcase
		end
	end

	assign cont = (state_q == ST_EXEC) && !terminal;
	assign done = (state_q == ST_EXEC) && terminal && out_free;

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = word_q;
		wr_data = rd_data | ({{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel);
		if (state_q == ST_CLR) begin
			wr_en   = 1'b1;
			wr_addr = clr_idx_q;
			wr_data = '0;
		end else if (done && do_write) begin
			wr_en = 1'b1;
		end
	end

	always_comb begin
		rd_en   = 1'b0;
		rd_addr = WIDX_W'(32'(position) >> BIT_W);
		if (accept && !in_bad) begin
			rd_en = 1'b1;
		end else if (cont) begin
			rd_en   = 1'b1;
			rd_addr = WIDX_W'(nxt_word);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_length_q <= bsfn_pkg::ACTIVE_LENGTH_RESET;
		end else if (cfg_valid && cfg_ready) begin
			active_length_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLR;
			clr_idx_q <= '0;
			count_q   <= '0;
		end else begin
			case (state_q)
				ST_CLR: begin
					clr_idx_q <= clr_idx_q + WIDX_W'(1);
					if (clr_idx_q == WIDX_W'(NUM_WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (done) begin
						state_q <= ST_IDLE;
						if (do_write) begin
							count_q <= count_q + bsfn_pkg::COUNT_W'(1);
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q    <= op;
			pos_q   <= position;
			lim_q   <= lim;
			bad_q   <= in_bad;
			first_q <= 1'b1;
			word_q  <= WIDX_W'(32'(position) >> BIT_W);
		end else if (cont) begin
			first_q <= 1'b0;
			word_q  <= WIDX_W'(nxt_word);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			present_q   <= r_present;
			found_q     <= r_found;
			status_q    <= r_status;
			count_out_q <= count_q + bsfn_pkg::COUNT_W'(do_write);
		end
	end

	assign out_valid      = out_valid_q;
	assign present        = present_q;
	assign found_position = found_q;
	assign member_count   = count_out_q;
	assign status         = status_q;

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == ST_EXEC)
		else $error("accepted item did not start execution");

	a_write_owner: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_CLR) || done)
		else $error("word memory written outside clearing or completion");

	a_no_read_write: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !wr_en)
		else $error("word memory read and written in one cycle");

	a_fail_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == bsfn_pkg::STAT_RANGE || status == bsfn_pkg::STAT_NONE)
		|-> !present && found_position == '0)
		else $error("failed result carries a position or presence");

endmodule
